/* design/frea_pkg.sv */
// frea_pkg: shared types and constants for the frame ring element allocator.
// Used by frea_ctrl, frea_dp and frame_ring_element_allocator.
`timescale 1ns / 1ps
package frea_pkg;
	localparam int CapW   = 25;
	localparam int OffW   = 24;
	localparam int FrameW = 32;
	localparam int FifW   = 4;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_REALLOC = 2'd1;
	localparam logic [1:0] STAT_TOO_BIG = 2'd2;

	localparam logic CFG_INIT_CAP = 1'b0;
	localparam logic CFG_FIF      = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RECLAIM, ST_OPEN, ST_END, ST_ROOM, ST_FIT, ST_GROW
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_RECLAIM, OP_OPEN, OP_END, OP_ROOM, OP_GRANT,
		OP_GROW_INIT, OP_GROW
	} op_t;

	typedef struct packed {
		logic can_reclaim;
		logic head_new;
		logic next_is_tail;
		logic fits;
		logic grow_stop;
		logic out_free;
	} dp_stat_t;
endpackage

/* design/frame_ring_element_allocator.sv */
// Frame ring element allocator, top level: frea_ctrl sequencer plus frea_dp datapath.
// Each request steps through the reclaim, open, end, room and fit states, then grow if it does not fit.
// Throughput: one request at a time; the tail reclaim walk (up to SEGMENTS-1 steps) and the
// growth loop add one step each, and fit and grow wait while the last result is not yet taken.
// Reset (arst_n, async): ring empty, capacity 1024 (MAX_CAPACITY if smaller), frames_in_flight 3, no result pending.
`timescale 1ns / 1ps
module frame_ring_element_allocator #(
	parameter int SEGMENTS     = 8,
	parameter int MAX_CAPACITY = 16777216
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // frame_number[31:0], request_count[56:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // element_offset[23:0], status[25:24], capacity_now[50:26]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [24:0] cfg_wdata
);
	import frea_pkg::*;

	dp_stat_t        st;
	op_t             op;
	logic [OffW-1:0] element_offset;
	logic [1:0]      status;
	logic [CapW-1:0] capacity_now;

	frea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.op       (op)
	);

	frea_dp #(
		.SEGMENTS     (SEGMENTS),
		.MAX_CAPACITY (MAX_CAPACITY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.st             (st),
		.frame_number   (s_axis_tdata[31:0]),
		.request_count  (s_axis_tdata[56:32]),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.element_offset (element_offset),
		.status         (status),
		.capacity_now   (capacity_now)
	);

	assign m_axis_tdata = {5'd0, capacity_now, status, element_offset};

`ifndef SYNTHESIS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (status == STAT_OK || status == STAT_REALLOC ||
		status == STAT_TOO_BIG))
		else $error("bad status code");
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status != STAT_OK) |-> element_offset == '0)
		else $error("nonzero offset on realloc or too large");
	a_cap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (capacity_now >= CapW'(2) &&
		27'(capacity_now) <= 27'(MAX_CAPACITY)))
		else $error("capacity out of range");
`endif
endmodule

/* design/frea_ctrl.sv */
// frea_ctrl: sequencer for one request (reclaim, open, fit, grow).
// Depends on frea_pkg; drives frea_dp through op_t commands.
`timescale 1ns / 1ps
module frea_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  frea_pkg::dp_stat_t st,
	output frea_pkg::op_t     op
);
	import frea_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_nx = ST_RECLAIM;
			ST_RECLAIM: if (!st.can_reclaim) state_nx = ST_OPEN;
			ST_OPEN:    if (!st.head_new || !st.next_is_tail) state_nx = ST_END;
			ST_END:     state_nx = ST_ROOM;
			ST_ROOM:    state_nx = ST_FIT;
			ST_FIT: begin
				if (!st.fits) state_nx = ST_GROW;
				else if (st.out_free) state_nx = ST_IDLE;
			end
			ST_GROW:    if (st.grow_stop && st.out_free) state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) op = OP_LOAD;
			end
			ST_RECLAIM: if (st.can_reclaim) op = OP_RECLAIM;
			ST_OPEN: begin
				if (st.head_new) op = st.next_is_tail ? OP_RECLAIM : OP_OPEN;
			end
			ST_END:  op = OP_END;
			ST_ROOM: op = OP_ROOM;
			ST_FIT: begin
				if (!st.fits) op = OP_GROW_INIT;
				else if (st.out_free) op = OP_GRANT;
			end
			ST_GROW: if (!st.grow_stop || st.out_free) op = OP_GROW;
			default: op = OP_NONE;
		endcase
	end
endmodule

/* design/frea_dp.sv */
// frea_dp: segment list, ring pointers, fit and growth arithmetic, result register.
// Depends on frea_pkg; commanded by frea_ctrl.
`timescale 1ns / 1ps
module frea_dp #(
	parameter int SEGMENTS     = 8,
	parameter int MAX_CAPACITY = 16777216
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  frea_pkg::op_t                 op,
	output frea_pkg::dp_stat_t            st,
	input  logic [frea_pkg::FrameW-1:0]   frame_number,
	input  logic [frea_pkg::CapW-1:0]     request_count,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [frea_pkg::CapW-1:0]     cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [frea_pkg::OffW-1:0]     element_offset,
	output logic [1:0]                    status,
	output logic [frea_pkg::CapW-1:0]     capacity_now
);
	import frea_pkg::*;

	localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SEGMENTS - 1);
	localparam logic [26:0] MAX_C = 27'(MAX_CAPACITY);
	localparam logic [CapW-1:0] CAP_RST = (1024 > MAX_CAPACITY) ?
		CapW'(MAX_CAPACITY) : CapW'(1024);

	function automatic logic [CapW-1:0] clamp_cap(input logic [CapW-1:0] v);
		if (v < CapW'(2)) return CapW'(2);
		if (27'(v) > MAX_C) return CapW'(MAX_CAPACITY);
		return v;
	endfunction

	logic [FrameW-1:0] segf_q [SEGMENTS];
	logic [CapW-1:0]   segc_q [SEGMENTS];
	logic [IW-1:0]     head_q, tail_q;
	logic [CapW-1:0]   used_q, cap_q;
	logic [OffW-1:0]   start_q;
	logic [FifW-1:0]   fif_q;
	logic [FrameW-1:0] frame_q;
	logic [CapW-1:0]   n_q, end_q, room_q;
	logic              pad_q;
	logic [26:0]       grow_q;
	logic              out_valid_q;
	logic [OffW-1:0]   off_q;
	logic [1:0]        stat_q;
	logic [CapW-1:0]   capo_q;

	// combinational helpers
	logic [IW-1:0]     head_nx, tail_nx;
	logic [CapW-1:0]   tail_cnt, rem, room_c, add_n;
	logic [25:0]       st_sum, se_sum, end_n;
	logic [FrameW:0]   age_lim;
	logic              pad_c;
	logic [26:0]       grow_nx;
	logic              grow_over;
	logic              out_set;

	always_comb begin
		head_nx  = (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
		tail_nx  = (tail_q == LAST_IDX) ? '0 : tail_q + IW'(1);
		tail_cnt = segc_q[tail_q];
		st_sum   = 26'(start_q) + 26'(tail_cnt);
		se_sum   = 26'(start_q) + 26'(used_q);
		age_lim  = {1'b0, segf_q[tail_q]} + (FrameW+1)'(fif_q);
		rem      = cap_q - end_q;
		end_n    = 26'(end_q) + 26'(n_q);
		pad_c    = (25'(start_q) < end_q) && (end_n > 26'(cap_q));
		if (pad_c)
			room_c = ((26'(used_q) + 26'(rem)) >= 26'(cap_q)) ? '0 : 25'(start_q);
		else if (used_q >= cap_q)
			room_c = '0;
		else if (end_q < 25'(start_q))
			room_c = 25'(start_q) - end_q;
		else
			room_c = rem;
		add_n     = pad_q ? rem + n_q : n_q;
		grow_nx   = grow_q + (grow_q >> 1);
		grow_over = grow_nx > MAX_C;
		out_set   = (op == OP_GRANT) ||
			((op == OP_GROW) && (grow_over || (grow_nx >= 27'(n_q))));
	end

	always_comb begin
		st.can_reclaim  = (tail_q != head_q) && ({1'b0, frame_q} >= age_lim);
		st.head_new     = frame_q != segf_q[head_q];
		st.next_is_tail = head_nx == tail_q;
		st.fits         = n_q <= room_q;
		st.grow_stop    = grow_over || (grow_nx >= 27'(n_q));
		st.out_free     = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SEGMENTS; i++) begin
				segf_q[i] <= '0;
				segc_q[i] <= '0;
			end
			head_q      <= IW'(1);
			tail_q      <= '0;
			used_q      <= '0;
			start_q     <= '0;
			cap_q       <= CAP_RST;
			fif_q       <= FifW'(3);
			out_valid_q <= 1'b0;
			off_q       <= '0;
			stat_q      <= STAT_OK;
			capo_q      <= '0;
		end else begin
			if (out_set) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_INIT_CAP: begin
						for (int i = 0; i < SEGMENTS; i++) begin
							segf_q[i] <= '0;
							segc_q[i] <= '0;
						end
						head_q  <= IW'(1);
						tail_q  <= '0;
						used_q  <= '0;
						start_q <= '0;
						cap_q   <= clamp_cap(cfg_wdata);
					end
					CFG_FIF: fif_q <= cfg_wdata[FifW-1:0];
					default: ;
				endcase
			end
			case (op)
				OP_RECLAIM: begin
					used_q  <= (used_q >= tail_cnt) ? used_q - tail_cnt : '0;
					start_q <= (st_sum >= 26'(cap_q)) ?
						OffW'(st_sum - 26'(cap_q)) : OffW'(st_sum);
					segc_q[tail_q] <= '0;
					segf_q[tail_q] <= '0;
					tail_q <= tail_nx;
				end
				OP_OPEN: begin
					head_q <= head_nx;
					segf_q[head_nx] <= frame_q;
					segc_q[head_nx] <= '0;
				end
				OP_GRANT: begin
					segc_q[head_q] <= segc_q[head_q] + add_n;
					used_q      <= used_q + add_n;
					off_q       <= pad_q ? '0 : OffW'(end_q);
					stat_q      <= STAT_OK;
					capo_q      <= cap_q;
				end
				OP_GROW: begin
					if (grow_over) begin
						off_q       <= '0;
						stat_q      <= STAT_TOO_BIG;
						capo_q      <= cap_q;
					end else if (grow_nx >= 27'(n_q)) begin
						for (int i = 0; i < SEGMENTS; i++) begin
							segf_q[i] <= '0;
							segc_q[i] <= (IW'(i) == head_q) ? n_q : '0;
						end
						used_q      <= n_q;
						start_q     <= '0;
						cap_q       <= CapW'(grow_nx);
						off_q       <= '0;
						stat_q      <= STAT_REALLOC;
						capo_q      <= CapW'(grow_nx);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				frame_q <= frame_number;
				n_q     <= request_count;
			end
			OP_END:  end_q <= (se_sum >= 26'(cap_q)) ? CapW'(se_sum - 26'(cap_q)) : CapW'(se_sum);
			OP_ROOM: begin
				pad_q  <= pad_c;
				room_q <= room_c;
			end
			OP_GROW_INIT: grow_q <= 27'(cap_q);
			OP_GROW:      grow_q <= grow_nx;
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign element_offset = off_q;
	assign status         = stat_q;
	assign capacity_now   = capo_q;
endmodule

/* test/frame_ring_element_allocator_checker.sv */
// Checker for the frame ring element allocator: watches both streams and the config port,
// predicts each result from its own model of the ring, and counts mismatches.
// Depends on frea_pkg for widths and status codes.
`timescale 1ns / 1ps
module frame_ring_element_allocator_checker #(
	parameter int SEGMENTS     = 8,
	parameter int MAX_CAPACITY = 16777216
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [55:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [24:0] cfg_wdata,
	output int          fails,
	output int          pending,
	output int          results,
	output int          reallocs,
	output int          too_bigs
);
	import frea_pkg::*;

	typedef struct packed {
		logic [CapW-1:0] cap;
		logic [1:0]      stat;
		logic [OffW-1:0] off;
	} grant_t;

	grant_t grants_due[$];

	longint unsigned ring_frame [SEGMENTS];
	longint unsigned ring_count [SEGMENTS];
	longint unsigned head_i, tail_i, used, first, ring_cap, init_cap, fif;

	function automatic longint unsigned clamp_cap(longint unsigned v);
		if (v < 2) return 2;
		if (v > MAX_CAPACITY) return MAX_CAPACITY;
		return v;
	endfunction

	function automatic void empty_segments();
		for (int i = 0; i < SEGMENTS; i++) begin
			ring_frame[i] = 0;
			ring_count[i] = 0;
		end
	endfunction

	function automatic void clear_ring();
		empty_segments();
		head_i = 1 % SEGMENTS;
		tail_i = 0;
		used = 0;
		first = 0;
		ring_cap = clamp_cap(init_cap);
	endfunction

	function automatic void drop_oldest();
		longint unsigned t, c;
		t = tail_i % SEGMENTS;
		c = ring_count[t];
		used = (used >= c) ? used - c : 0;
		first = (first + c) % ring_cap;
		ring_count[t] = 0;
		ring_frame[t] = 0;
		tail_i = (t + 1) % SEGMENTS;
	endfunction

	function automatic grant_t allocate(longint unsigned frame, longint unsigned n);
		longint unsigned head, nxt, fin, room, rem, grown;
		bit pad, too_big;
		grant_t g;
		g = '0;
		while (tail_i != head_i && frame >= ring_frame[tail_i % SEGMENTS] + fif)
			drop_oldest();
		head = head_i % SEGMENTS;
		if (frame != ring_frame[head]) begin
			nxt = (head + 1) % SEGMENTS;
			if (nxt == tail_i % SEGMENTS)
				drop_oldest();
			head_i = nxt;
			head = nxt;
			ring_frame[head] = frame;
			ring_count[head] = 0;
		end
		fin = (first + used) % ring_cap;
		pad = (first < fin) && (fin + n > ring_cap);
		if (pad)
			room = (used + (ring_cap - fin) >= ring_cap) ? 0 : first;
		else if (used >= ring_cap)
			room = 0;
		else if (fin < first)
			room = first - fin;
		else
			room = ring_cap - fin;
		g.stat = STAT_OK;
		if (n <= room) begin
			if (pad) begin
				rem = ring_cap - fin;
				ring_count[head] = (ring_count[head] + rem) & 64'h1FF_FFFF;
				used += rem;
				fin = 0;
			end
			g.off = fin[OffW-1:0];
		end else begin
			grown = ring_cap;
			too_big = 0;
			do begin
				grown = grown + (grown >> 1);
				if (grown > MAX_CAPACITY) begin
					too_big = 1;
					break;
				end
			end while (grown < n);
			if (too_big) begin
				g.stat = STAT_TOO_BIG;
				g.cap = ring_cap[CapW-1:0];
				return g;
			end
			empty_segments();
			used = 0;
			first = 0;
			ring_cap = grown;
			g.off = '0;
			g.stat = STAT_REALLOC;
		end
		ring_count[head] = (ring_count[head] + n) & 64'h1FF_FFFF;
		used += n;
		g.cap = ring_cap[CapW-1:0];
		return g;
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
		fails++;
	endtask

	assign pending = grants_due.size();

	always @(posedge clk or negedge arst_n) begin
		grant_t g, w;
		if (!arst_n) begin
			init_cap = 1024;
			fif = 3;
			clear_ring();
			grants_due.delete();
			fails = 0;
			results = 0;
			reallocs = 0;
			too_bigs = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_INIT_CAP) begin
					init_cap = cfg_wdata;
					clear_ring();
				end else begin
					fif = cfg_wdata[FifW-1:0];
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				grants_due.push_back(allocate(s_axis_tdata[31:0], s_axis_tdata[56:32]));
			if (m_axis_tvalid && m_axis_tready) begin
				g = m_axis_tdata[50:0];
				results++;
				if (grants_due.size() == 0) begin
					$display("%0t result transfer with nothing outstanding", $time);
					fails++;
				end else begin
					w = grants_due.pop_front();
					if (g.off != w.off) report("element_offset", g.off, w.off);
					if (g.stat != w.stat) report("status", g.stat, w.stat);
					if (g.cap != w.cap) report("capacity_now", g.cap, w.cap);
					if (w.stat == STAT_REALLOC) reallocs++;
					if (w.stat == STAT_TOO_BIG) too_bigs++;
				end
			end
		end
	end
endmodule

/* test/frame_ring_element_allocator_test.sv */
// Top of the frame ring element allocator testbench: clock, reset, request and config stimulus.
// Depends on frame_ring_element_allocator, frame_ring_element_allocator_checker and frea_pkg.
`timescale 1ns / 1ps
module frame_ring_element_allocator_test;
	import frea_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE = 60;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [55:0] m_axis_tdata;
	logic        cfg_we = 0;
	logic        cfg_index = CFG_INIT_CAP;
	logic [24:0] cfg_wdata = '0;

	int fails, pending, results, reallocs, too_bigs;
	int tx_idle = 0, rx_idle = 0;
	int cycles = 0, sent = 0;
	logic [31:0] frame_now = 0;

	frame_ring_element_allocator dut (.*);
	frame_ring_element_allocator_checker chk (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[frame_ring_element_allocator] ERROR");
			$finish;
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= rx_idle);

	task automatic request(logic [31:0] frame, logic [24:0] n);
		while ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {7'b0, n, frame};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		sent++;
	endtask

	task automatic settle_and_write(logic idx, logic [24:0] val);
		s_axis_tvalid <= 0;
		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// Mostly a frame at a time with several requests each; rare jumps and big counts.
	task automatic random_run(int items);
		int r;
		logic [24:0] n;
		repeat (items) begin
			r = $urandom_range(99);
			if (r < 33) frame_now = frame_now + 1;
			else if (r < 36) frame_now = frame_now + $urandom_range(2, 20);
			else if (r < 37) frame_now = $urandom;
			r = $urandom_range(99);
			if (r < 80) n = 25'($urandom_range(0, 300));
			else if (r < 96) n = 25'($urandom_range(0, 5000));
			else if (r < 98) n = 25'($urandom_range(0, 32'h1FF_FFFF));
			else n = 25'($urandom);
			if (n > 25'd16777216) n = 25'(16777216 - $urandom_range(0, 1000));
			request(frame_now, n);
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty ring, full ring, growth, too large, frame extremes
		request(0, 0);
		request(0, 1024);
		request(0, 0);
		request(1, 1);
		request(1, 700);
		request(2, 900);
		request(5, 16777216);
		request(6, 100);
		request(7, 1000);
		request(32'hFFFF_FFFE, 16777215);
		request(32'hFFFF_FFFF, 300);
		request(32'hFFFF_FFFF, 0);
		request(0, 5);
		for (int f = 100; f < 110; f++) request(f, 250);

		settle_and_write(CFG_INIT_CAP, 0);
		settle_and_write(CFG_FIF, 15);
		tx_idle = 35; rx_idle = 61;
		frame_now = 200;
		random_run(40);
		settle_and_write(CFG_INIT_CAP, 1000);
		settle_and_write(CFG_FIF, 0);
		random_run(540);

		settle_and_write(CFG_INIT_CAP, 25'h1FF_FFFF);
		settle_and_write(CFG_FIF, 15);
		tx_idle = 61; rx_idle = 35;
		random_run(60);
		settle_and_write(CFG_INIT_CAP, 700);
		settle_and_write(CFG_FIF, 1);
		random_run(520);

		settle_and_write(CFG_INIT_CAP, 2);
		settle_and_write(CFG_FIF, 3);
		tx_idle = 0; rx_idle = 0;
		random_run(40);
		settle_and_write(CFG_INIT_CAP, 1500);
		settle_and_write(CFG_FIF, 2);
		random_run(550);

		s_axis_tvalid <= 0;
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		$display("ran %0d requests over six ring settings, %0d results checked", sent, results);
		$display("%0d grants after regrowth, %0d rejected as too large", reallocs, too_bigs);
		if (fails == 0)
			$display("[frame_ring_element_allocator] OK");
		else
			$display("[frame_ring_element_allocator] ERROR");
		$finish;
	end
endmodule
